// ----- rtl/m3h_pkg.sv -----
package m3h_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd1;

	localparam logic [63:0] SEED_RST = 64'd80085;

	// Block mix and finalization constants
	localparam logic [31:0] C1_32   = 32'hCC9E2D51;
	localparam logic [31:0] C2_32   = 32'h1B873593;
	localparam logic [31:0] ADD_32  = 32'hE6546B64;
	localparam logic [63:0] C1_64   = 64'h87C37B91114253D5;
	localparam logic [63:0] C2_64   = 64'h4CF5AD432745937F;
	localparam logic [63:0] ADD1_64 = 64'h0000000052DCE729;
	localparam logic [63:0] ADD2_64 = 64'h0000000038495AB5;
	localparam logic [31:0] F1_32   = 32'h85EBCA6B;
	localparam logic [31:0] F2_32   = 32'hC2B2AE35;
	localparam logic [63:0] F1_64   = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] F2_64   = 64'hC4CEB9FE1A85EC53;

	// Micro-op codes
	localparam logic [4:0] OP_LDLO   = 5'd0;
	localparam logic [4:0] OP_LDHI   = 5'd1;
	localparam logic [4:0] OP_MUL    = 5'd2;
	localparam logic [4:0] OP_ROTK   = 5'd3;
	localparam logic [4:0] OP_XSHK   = 5'd4;
	localparam logic [4:0] OP_H1MIX  = 5'd5;
	localparam logic [4:0] OP_H1MUL5 = 5'd6;
	localparam logic [4:0] OP_H2MIX  = 5'd7;
	localparam logic [4:0] OP_H2MUL5 = 5'd8;
	localparam logic [4:0] OP_H1XKT  = 5'd9;
	localparam logic [4:0] OP_H2XKT  = 5'd10;
	localparam logic [4:0] OP_LEN    = 5'd11;
	localparam logic [4:0] OP_ADD12  = 5'd12;
	localparam logic [4:0] OP_ADD21  = 5'd13;
	localparam logic [4:0] OP_KH1    = 5'd14;
	localparam logic [4:0] OP_KH2    = 5'd15;
	localparam logic [4:0] OP_H1K    = 5'd16;
	localparam logic [4:0] OP_H2K    = 5'd17;
	localparam logic [4:0] OP_BEND   = 5'd18;
	localparam logic [4:0] OP_FEND   = 5'd19;

	// Multiplier constant selects
	localparam logic [5:0] MC_C1_32 = 6'd0;
	localparam logic [5:0] MC_C2_32 = 6'd1;
	localparam logic [5:0] MC_F1_32 = 6'd2;
	localparam logic [5:0] MC_F2_32 = 6'd3;
	localparam logic [5:0] MC_C1_64 = 6'd4;
	localparam logic [5:0] MC_C2_64 = 6'd5;
	localparam logic [5:0] MC_F1_64 = 6'd6;
	localparam logic [5:0] MC_F2_64 = 6'd7;
	localparam logic [5:0] ARG_NONE = 6'd0;

	// Program entry points
	localparam logic [5:0] PC_N_BLK = 6'd0;
	localparam logic [5:0] PC_N_FIN = 6'd7;
	localparam logic [5:0] PC_W_BLK = 6'd20;
	localparam logic [5:0] PC_W_FIN = 6'd33;

	typedef struct packed {
		logic [4:0] op;
		logic [5:0] arg;
	} ucode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic [63:0] seed;
		logic        wide;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic result_valid;
	} core_stat_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] amt);
		logic [127:0] d;
		d = {v, v} << amt;
		return d[127:64];
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
		logic [63:0] d;
		d = {v, v} << amt;
		return d[63:32];
	endfunction

	function automatic logic [63:0] mul_const(input logic [5:0] sel);
		logic [63:0] c;
		case (sel)
			MC_C1_32: c = {32'd0, C1_32};
			MC_C2_32: c = {32'd0, C2_32};
			MC_F1_32: c = {32'd0, F1_32};
			MC_F2_32: c = {32'd0, F2_32};
			MC_C1_64: c = C1_64;
			MC_C2_64: c = C2_64;
			MC_F1_64: c = F1_64;
			MC_F2_64: c = F2_64;
			default:  c = 64'd0;
		endcase
		return c;
	endfunction

	// Microcode: 32-bit block, 32-bit finish, 64-bit block, 64-bit finish
	function automatic ucode_t ucode(input logic [5:0] pc);
		ucode_t u;
		case (pc)
			6'd0:  u = {OP_LDLO,   ARG_NONE};
			6'd1:  u = {OP_MUL,    MC_C1_32};
			6'd2:  u = {OP_ROTK,   6'd15};
			6'd3:  u = {OP_MUL,    MC_C2_32};
			6'd4:  u = {OP_H1MIX,  ARG_NONE};
			6'd5:  u = {OP_H1MUL5, ARG_NONE};
			6'd6:  u = {OP_BEND,   ARG_NONE};
			6'd7:  u = {OP_LDLO,   ARG_NONE};
			6'd8:  u = {OP_MUL,    MC_C1_32};
			6'd9:  u = {OP_ROTK,   6'd15};
			6'd10: u = {OP_MUL,    MC_C2_32};
			6'd11: u = {OP_H1XKT,  ARG_NONE};
			6'd12: u = {OP_LEN,    ARG_NONE};
			6'd13: u = {OP_KH1,    ARG_NONE};
			6'd14: u = {OP_XSHK,   6'd16};
			6'd15: u = {OP_MUL,    MC_F1_32};
			6'd16: u = {OP_XSHK,   6'd13};
			6'd17: u = {OP_MUL,    MC_F2_32};
			6'd18: u = {OP_XSHK,   6'd16};
			6'd19: u = {OP_FEND,   ARG_NONE};
			6'd20: u = {OP_LDLO,   ARG_NONE};
			6'd21: u = {OP_MUL,    MC_C1_64};
			6'd22: u = {OP_ROTK,   6'd31};
			6'd23: u = {OP_MUL,    MC_C2_64};
			6'd24: u = {OP_H1MIX,  ARG_NONE};
			6'd25: u = {OP_H1MUL5, ARG_NONE};
			6'd26: u = {OP_LDHI,   ARG_NONE};
			6'd27: u = {OP_MUL,    MC_C2_64};
			6'd28: u = {OP_ROTK,   6'd33};
			6'd29: u = {OP_MUL,    MC_C1_64};
			6'd30: u = {OP_H2MIX,  ARG_NONE};
			6'd31: u = {OP_H2MUL5, ARG_NONE};
			6'd32: u = {OP_BEND,   ARG_NONE};
			6'd33: u = {OP_LDHI,   ARG_NONE};
			6'd34: u = {OP_MUL,    MC_C2_64};
			6'd35: u = {OP_ROTK,   6'd33};
			6'd36: u = {OP_MUL,    MC_C1_64};
			6'd37: u = {OP_H2XKT,  ARG_NONE};
			6'd38: u = {OP_LDLO,   ARG_NONE};
			6'd39: u = {OP_MUL,    MC_C1_64};
			6'd40: u = {OP_ROTK,   6'd31};
			6'd41: u = {OP_MUL,    MC_C2_64};
			6'd42: u = {OP_H1XKT,  ARG_NONE};
			6'd43: u = {OP_LEN,    ARG_NONE};
			6'd44: u = {OP_ADD12,  ARG_NONE};
			6'd45: u = {OP_ADD21,  ARG_NONE};
			6'd46: u = {OP_KH1,    ARG_NONE};
			6'd47: u = {OP_XSHK,   6'd33};
			6'd48: u = {OP_MUL,    MC_F1_64};
			6'd49: u = {OP_XSHK,   6'd33};
			6'd50: u = {OP_MUL,    MC_F2_64};
			6'd51: u = {OP_XSHK,   6'd33};
			6'd52: u = {OP_H1K,    ARG_NONE};
			6'd53: u = {OP_KH2,    ARG_NONE};
			6'd54: u = {OP_XSHK,   6'd33};
			6'd55: u = {OP_MUL,    MC_F1_64};
			6'd56: u = {OP_XSHK,   6'd33};
			6'd57: u = {OP_MUL,    MC_F2_64};
			6'd58: u = {OP_XSHK,   6'd33};
			6'd59: u = {OP_H2K,    ARG_NONE};
			6'd60: u = {OP_ADD12,  ARG_NONE};
			6'd61: u = {OP_ADD21,  ARG_NONE};
			6'd62: u = {OP_FEND,   ARG_NONE};
			default: u = {OP_BEND, ARG_NONE};
		endcase
		return u;
	endfunction

endpackage

// ----- rtl/m3h_mul.sv -----
// Shared 32x32 multiplier; a 64-bit product (mod 2^64) takes three passes
module m3h_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        wide,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] product,
	output logic        done
);

	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;

	logic        busy_q;
	logic        done_q;
	logic [1:0]  phase_q;
	logic [63:0] acc_q;
	logic [31:0] a_h;
	logic [31:0] b_h;
	logic [63:0] p;
	logic        last;

	// Operand halves per pass: lo*lo, lo*hi, hi*lo
	always_comb begin
		a_h = (phase_q == PH_HL) ? a[63:32] : a[31:0];
		b_h = (phase_q == PH_LH) ? b[63:32] : b[31:0];
		p = a_h * b_h;
		last = wide ? (phase_q == PH_HL) : (phase_q == PH_LL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			phase_q <= PH_LL;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			phase_q <= PH_LL;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Accumulator: cross terms only feed the upper word
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (phase_q == PH_LL) begin
				acc_q <= p;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + p[31:0];
			end
		end
	end

	assign product = acc_q;
	assign done = done_q;

endmodule

// ----- rtl/m3h_core.sv -----
// Byte gathering, hash lanes and the microcoded sequencer around the multiplier
module m3h_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  m3h_pkg::item_t      item,
	input  m3h_pkg::cfg_t       cfg,
	input  logic                restart,
	input  logic                out_free,
	output m3h_pkg::core_stat_t stat,
	output logic [63:0]         digest
);

	logic [63:0]  h1_q, h1_d;
	logic [63:0]  h2_q, h2_d;
	logic [63:0]  k_q, k_d;
	logic [63:0]  total_q, total_d;
	logic [127:0] blk_q, blk_d;
	logic [3:0]   cnt_q, cnt_d;
	logic         busy_q, busy_d;
	logic         fin_q, fin_d;
	logic [5:0]   pc_q, pc_d;
	logic         mul_wait_q, mul_wait_d;

	m3h_pkg::ucode_t uc;
	logic        mode;
	logic        mul_start;
	logic        mul_done;
	logic [63:0] mul_p;
	logic [63:0] lane_seed;
	logic [4:0]  cnt_inc;
	logic        blk_full;
	logic        result_valid;
	logic [31:0] h1_32;
	logic [63:0] h1_x;

	assign uc = m3h_pkg::ucode(pc_q);
	assign mode = cfg.wide;
	assign lane_seed = mode ? cfg.seed : {32'd0, cfg.seed[31:0]};
	assign cnt_inc = {1'b0, cnt_q} + 5'd1;
	assign blk_full = (cnt_inc == (mode ? 5'd16 : 5'd4));
	assign mul_start = busy_q && (uc.op == m3h_pkg::OP_MUL) && !mul_wait_q;
	assign result_valid = busy_q && (uc.op == m3h_pkg::OP_FEND) && out_free;
	assign h1_x = h1_q ^ k_q;
	assign h1_32 = m3h_pkg::rotl32(h1_x[31:0], 5'd13);

	m3h_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.wide    (mode),
		.a       (k_q),
		.b       (m3h_pkg::mul_const(uc.arg)),
		.product (mul_p),
		.done    (mul_done)
	);

	// Next state: restart, byte absorb when idle, one micro-op per step when busy
	always_comb begin
		h1_d = h1_q;
		h2_d = h2_q;
		k_d = k_q;
		total_d = total_q;
		blk_d = blk_q;
		cnt_d = cnt_q;
		busy_d = busy_q;
		fin_d = fin_q;
		pc_d = pc_q;
		mul_wait_d = mul_wait_q;
		if (restart) begin
			h1_d = lane_seed;
			h2_d = lane_seed;
			total_d = 64'd0;
			blk_d = 128'd0;
			cnt_d = 4'd0;
			busy_d = 1'b0;
			fin_d = 1'b0;
		end else if (!busy_q) begin
			if (accept) begin
				if (item.byte_present) begin
					blk_d[{cnt_q, 3'b000} +: 8] = item.data_byte;
					total_d = total_q + 64'd1;
					cnt_d = cnt_inc[3:0];
				end
				if (item.byte_present && blk_full) begin
					busy_d = 1'b1;
					pc_d = mode ? m3h_pkg::PC_W_BLK : m3h_pkg::PC_N_BLK;
					fin_d = item.end_of_message;
				end else if (item.end_of_message) begin
					busy_d = 1'b1;
					pc_d = mode ? m3h_pkg::PC_W_FIN : m3h_pkg::PC_N_FIN;
					fin_d = 1'b0;
				end
			end
		end else begin
			pc_d = pc_q + 6'd1;
			case (uc.op)
				m3h_pkg::OP_LDLO: begin
					k_d = mode ? blk_q[63:0] : {32'd0, blk_q[31:0]};
				end
				m3h_pkg::OP_LDHI: begin
					k_d = blk_q[127:64];
				end
				m3h_pkg::OP_MUL: begin
					pc_d = pc_q;
					if (mul_start) begin
						mul_wait_d = 1'b1;
					end
					if (mul_done) begin
						k_d = mode ? mul_p : {32'd0, mul_p[31:0]};
						mul_wait_d = 1'b0;
						pc_d = pc_q + 6'd1;
					end
				end
				m3h_pkg::OP_ROTK: begin
					k_d = mode ? m3h_pkg::rotl64(k_q, uc.arg)
						: {32'd0, m3h_pkg::rotl32(k_q[31:0], uc.arg[4:0])};
				end
				m3h_pkg::OP_XSHK: begin
					k_d = k_q ^ (k_q >> uc.arg);
				end
				m3h_pkg::OP_H1MIX: begin
					h1_d = mode ? (m3h_pkg::rotl64(h1_x, 6'd27) + h2_q) : {32'd0, h1_32};
				end
				m3h_pkg::OP_H1MUL5: begin
					h1_d = mode ? ((h1_q << 2) + h1_q + m3h_pkg::ADD1_64)
						: {32'd0, (h1_q[31:0] << 2) + h1_q[31:0] + m3h_pkg::ADD_32};
				end
				m3h_pkg::OP_H2MIX: begin
					h2_d = m3h_pkg::rotl64(h2_q ^ k_q, 6'd31) + h1_q;
				end
				m3h_pkg::OP_H2MUL5: begin
					h2_d = (h2_q << 2) + h2_q + m3h_pkg::ADD2_64;
				end
				m3h_pkg::OP_H1XKT: begin
					if (cnt_q != 4'd0) begin
						h1_d = h1_x;
					end
				end
				m3h_pkg::OP_H2XKT: begin
					if (cnt_q > 4'd8) begin
						h2_d = h2_q ^ k_q;
					end
				end
				m3h_pkg::OP_LEN: begin
					h1_d = h1_q ^ (mode ? total_q : {32'd0, total_q[31:0]});
					h2_d = h2_q ^ (mode ? total_q : {32'd0, total_q[31:0]});
				end
				m3h_pkg::OP_ADD12: h1_d = h1_q + h2_q;
				m3h_pkg::OP_ADD21: h2_d = h2_q + h1_q;
				m3h_pkg::OP_KH1:   k_d = h1_q;
				m3h_pkg::OP_KH2:   k_d = h2_q;
				m3h_pkg::OP_H1K:   h1_d = k_q;
				m3h_pkg::OP_H2K:   h2_d = k_q;
				m3h_pkg::OP_BEND: begin
					blk_d = 128'd0;
					cnt_d = 4'd0;
					if (fin_q) begin
						fin_d = 1'b0;
						pc_d = mode ? m3h_pkg::PC_W_FIN : m3h_pkg::PC_N_FIN;
					end else begin
						busy_d = 1'b0;
					end
				end
				m3h_pkg::OP_FEND: begin
					pc_d = pc_q;
					if (out_free) begin
						h1_d = lane_seed;
						h2_d = lane_seed;
						total_d = 64'd0;
						blk_d = 128'd0;
						cnt_d = 4'd0;
						busy_d = 1'b0;
					end
				end
				default: busy_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q <= m3h_pkg::SEED_RST & 64'h00000000FFFFFFFF;
			h2_q <= m3h_pkg::SEED_RST & 64'h00000000FFFFFFFF;
			total_q <= 64'd0;
			blk_q <= 128'd0;
			cnt_q <= 4'd0;
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			pc_q <= m3h_pkg::PC_N_BLK;
			mul_wait_q <= 1'b0;
		end else begin
			h1_q <= h1_d;
			h2_q <= h2_d;
			total_q <= total_d;
			blk_q <= blk_d;
			cnt_q <= cnt_d;
			busy_q <= busy_d;
			fin_q <= fin_d;
			pc_q <= pc_d;
			mul_wait_q <= mul_wait_d;
		end
	end

	// Working key register
	always_ff @(posedge clk) begin
		k_q <= k_d;
	end

	assign stat.idle = !busy_q;
	assign stat.result_valid = result_valid;
	assign digest = mode ? (h1_q ^ h2_q) : {32'd0, k_q[31:0]};

	// Checks
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy_q)
		else $error("request accepted while sequencer busy");

	a_mul_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> mul_wait_q)
		else $error("multiplier answered without a pending request");

	a_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !restart |=> !busy_q)
		else $error("sequencer still busy after digest");

	// Mode seen here already carries a pending register write, so skip that cycle
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !restart |-> (mode || cnt_q < 4'd4))
		else $error("buffered byte count reached block size while idle");

endmodule

// ----- rtl/murmur3_stream_hash.sv -----
// An item that does not complete a block is absorbed in its accept cycle; completing a block
// keeps in_ready low while the block is mixed. Finalization follows any block mix and keeps
// in_ready low until the digest can be passed to the output register. Both run on the
// single shared 32x32 multiplier: 1 pass per 32-bit product, 3 passes per 64-bit product.
// Reset (arst_n low) loads seed 80085, 32-bit mode, and an empty message; a configuration
// write also restarts the message.
module murmur3_stream_hash (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           byte_present,
	input  logic                           end_of_message,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [63:0]                    digest,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [m3h_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data
);

	m3h_pkg::cfg_t       cfg_q, cfg_nx;
	m3h_pkg::item_t      item;
	m3h_pkg::core_stat_t stat;
	logic                cfg_fire;
	logic                restart;
	logic                accept;
	logic                out_free;
	logic                out_valid_q;
	logic [63:0]         digest_q;
	logic [63:0]         core_digest;

	assign cfg_ready = stat.idle;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_ready = stat.idle && !cfg_valid;
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign item = {data_byte, byte_present, end_of_message};

	// Register write decode
	always_comb begin
		cfg_nx = cfg_q;
		restart = 1'b0;
		if (cfg_fire) begin
			case (cfg_index)
				m3h_pkg::REG_SEED: begin
					cfg_nx.seed = cfg_data;
					restart = 1'b1;
				end
				m3h_pkg::REG_MODE: begin
					cfg_nx.wide = cfg_data[0];
					restart = 1'b1;
				end
				default: restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed <= m3h_pkg::SEED_RST;
			cfg_q.wide <= 1'b0;
		end else begin
			cfg_q <= cfg_nx;
		end
	end

	m3h_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg_nx),
		.restart  (restart),
		.out_free (out_free),
		.stat     (stat),
		.digest   (core_digest)
	);

	// Output request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.result_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.result_valid) begin
			digest_q <= core_digest;
		end
	end

	assign out_valid = out_valid_q;
	assign digest = digest_q;

endmodule
